[rtl/ordered_dither_dot_plane_writer_unit_assert.svh]
// Assertion macros shared by the dot plane writer modules.
// Needs nothing else; included by the modules that carry checks.
`ifndef ORDERED_DITHER_DOT_PLANE_WRITER_UNIT_ASSERT_SVH
`define ORDERED_DITHER_DOT_PLANE_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent holds -> consequent holds in the same cycle
`define ODW_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("odw check failed");
// antecedent holds -> consequent holds in the next cycle
`define ODW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("odw check failed");
`else
`define ODW_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ODW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/odw_pkg.sv]
// Types and constants of the ordered dither dot plane writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package odw_pkg;

    localparam int REPEAT_W        = 5;
    localparam int MAX_REPEAT      = 16;
    localparam int POSITION_BITS   = 12;
    localparam int START_W         = 12;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam logic [3:0] THRESH_FLIP = 4'hf;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_COLOUR     = 3'd1,
        REG_ROWS_LOW   = 3'd2,
        REG_ROWS_HIGH  = 3'd3,
        REG_START      = 3'd4
    } cfg_reg_t;

    // how a pixel decides its clear flags
    typedef enum logic [1:0] {
        MODE_GREY   = 2'd0,
        MODE_COLOUR = 2'd1,
        MODE_THRESH = 2'd2
    } mode_t;

    // one classified pixel, as queued between front and back
    typedef struct packed {
        logic                  first;
        mode_t                 mode;
        logic                  thr_clear;
        logic [3:0][7:0]       row_entries;
        logic [7:0]            white;
        logic [7:0]            yellow;
        logic [7:0]            magenta;
        logic [7:0]            cyan;
        logic [REPEAT_W-1:0]   count;
    } item_t;

endpackage

[rtl/odw_front.sv]
// Front end: configuration registers, pixel accept and classification.
// Depends on odw_pkg; feeds odw_queue.
`timescale 1ns / 1ps
module odw_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [odw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [odw_pkg::CFG_DATA_W-1:0]     cfg_data,
    // source pixels
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_first_of_row,
    input  logic [1:0]                         s_row_low,
    input  logic [7:0]                         s_white_level,
    input  logic [7:0]                         s_yellow_level,
    input  logic [7:0]                         s_magenta_level,
    input  logic [7:0]                         s_cyan_level,
    input  logic [odw_pkg::REPEAT_W-1:0]       s_repeat_count,
    // towards the queue
    output logic                               push_valid,
    input  logic                               push_ready,
    output odw_pkg::item_t                     push_item,
    output logic [odw_pkg::START_W-1:0]        start_position
);

    logic [3:0]                     threshold_reg;
    logic                           colour_reg;
    logic [63:0]                    rows_low_reg;
    logic [63:0]                    rows_high_reg;
    logic [odw_pkg::START_W-1:0]    start_reg;

    logic [63:0]                    rows_word;
    logic [31:0]                    rows_half;
    logic [odw_pkg::REPEAT_W-1:0]   count_sat;

    // register file, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            colour_reg    <= 1'b0;
            rows_low_reg  <= '0;
            rows_high_reg <= '0;
            start_reg     <= '0;
        end else if (cfg_valid) begin
            case (odw_pkg::cfg_reg_t'(cfg_index))
                odw_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[3:0];
                odw_pkg::REG_COLOUR:    colour_reg    <= cfg_data[0];
                odw_pkg::REG_ROWS_LOW:  rows_low_reg  <= cfg_data;
                odw_pkg::REG_ROWS_HIGH: rows_high_reg <= cfg_data;
                odw_pkg::REG_START:     start_reg     <= cfg_data[odw_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    assign start_position = start_reg;

    // matrix row for this pixel: four bytes, column 0 lowest
    assign rows_word = s_row_low[1] ? rows_high_reg : rows_low_reg;
    assign rows_half = s_row_low[0] ? rows_word[63:32] : rows_word[31:0];

    // repeat runs longer than the limit are cut to the limit
    always_comb begin
        if (int'(s_repeat_count) > odw_pkg::MAX_REPEAT) begin
            count_sat = odw_pkg::REPEAT_W'(odw_pkg::MAX_REPEAT);
        end else begin
            count_sat = s_repeat_count;
        end
    end

    // classify and hand over
    always_comb begin
        push_item.first       = s_first_of_row;
        if (threshold_reg != 4'd0) begin
            push_item.mode = odw_pkg::MODE_THRESH;
        end else if (colour_reg) begin
            push_item.mode = odw_pkg::MODE_COLOUR;
        end else begin
            push_item.mode = odw_pkg::MODE_GREY;
        end
        push_item.thr_clear   = (s_white_level <= {4'd0, threshold_reg ^ odw_pkg::THRESH_FLIP});
        push_item.row_entries = rows_half;
        push_item.white       = s_white_level;
        push_item.yellow      = s_yellow_level;
        push_item.magenta     = s_magenta_level;
        push_item.cyan        = s_cyan_level;
        push_item.count       = count_sat;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

[rtl/odw_queue.sv]
// Short register queue of classified pixels between front and back.
// Depends on odw_pkg and the assertion header.
`timescale 1ns / 1ps
`include "ordered_dither_dot_plane_writer_unit_assert.svh"
module odw_queue #(
    parameter int DEPTH = odw_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  odw_pkg::item_t    push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output odw_pkg::item_t    pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    odw_pkg::item_t     slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ODW_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ODW_ASSERT_NEXT(a_fill_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))
    `ODW_ASSERT_NEXT(a_fill_down, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

[rtl/odw_back.sv]
// Back end: walks each pixel's repeat run into the output register, one dot per cycle while that register is free.
// Depends on odw_pkg and the assertion header; fed by odw_queue.
`timescale 1ns / 1ps
`include "ordered_dither_dot_plane_writer_unit_assert.svh"
module odw_back #(
    parameter int POSITION_BITS = odw_pkg::POSITION_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [odw_pkg::START_W-1:0]     start_position,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  odw_pkg::item_t                  pop_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [POSITION_BITS-1:0]        m_dot_position,
    output logic                            m_clear_blue,
    output logic                            m_clear_green,
    output logic                            m_clear_red,
    output logic                            m_last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                         state_reg;
    logic [POSITION_BITS-1:0]       pos_reg;
    logic [odw_pkg::REPEAT_W-1:0]   remain_reg;
    odw_pkg::item_t                 item_reg;
    logic                           m_valid_reg;
    logic [POSITION_BITS-1:0]       dot_pos_reg;
    logic                           clear_b_reg;
    logic                           clear_g_reg;
    logic                           clear_r_reg;
    logic                           last_reg;

    logic                           out_free;
    logic                           emit;
    logic [7:0]                     level;
    logic                           white_ok;
    logic                           clr_b;
    logic                           clr_g;
    logic                           clr_r;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (state_reg == ST_RUN) && out_free;
    assign pop_ready = (state_reg == ST_IDLE);

    // per-dot decision, column from the low position bits
    assign level    = item_reg.row_entries[pos_reg[1:0]];
    assign white_ok = (item_reg.white <= level);

    always_comb begin
        case (item_reg.mode)
            odw_pkg::MODE_THRESH: begin
                clr_b = item_reg.thr_clear;
                clr_g = item_reg.thr_clear;
                clr_r = item_reg.thr_clear;
            end
            odw_pkg::MODE_COLOUR: begin
                clr_b = white_ok && (item_reg.yellow <= level);
                clr_g = white_ok && (item_reg.magenta <= level);
                clr_r = white_ok && (item_reg.cyan <= level);
            end
            default: begin
                clr_b = white_ok;
                clr_g = white_ok;
                clr_r = white_ok;
            end
        endcase
    end

    // sequencer and dot position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // output register fills on a dot, empties when taken
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        remain_reg <= pop_item.count;
                        if (pop_item.first) begin
                            pos_reg <= POSITION_BITS'(start_position);
                        end
                        if (pop_item.count != '0) begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (out_free) begin
                        pos_reg     <= pos_reg + POSITION_BITS'(1);
                        remain_reg  <= remain_reg - odw_pkg::REPEAT_W'(1);
                        if (remain_reg == odw_pkg::REPEAT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload of the current pixel and of the output register
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            item_reg <= pop_item;
        end
        if (emit) begin
            dot_pos_reg <= pos_reg;
            clear_b_reg <= clr_b;
            clear_g_reg <= clr_g;
            clear_r_reg <= clr_r;
            last_reg    <= (remain_reg == odw_pkg::REPEAT_W'(1));
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dot_position = dot_pos_reg;
    assign m_clear_blue   = clear_b_reg;
    assign m_clear_green  = clear_g_reg;
    assign m_clear_red    = clear_r_reg;
    assign m_last_of_run  = last_reg;

    `ODW_ASSERT_IMPLY(a_run_has_dots, aclk, aresetn, state_reg == ST_RUN, remain_reg != '0)
    `ODW_ASSERT_NEXT(a_emit_shows, aclk, aresetn, emit, m_valid_reg)
    `ODW_ASSERT_NEXT(a_last_ends_run, aclk, aresetn, emit && (remain_reg == odw_pkg::REPEAT_W'(1)), state_reg == ST_IDLE && m_last_of_run)
    `ODW_ASSERT_NEXT(a_pos_steps, aclk, aresetn, emit, pos_reg == $past(pos_reg) + POSITION_BITS'(1))

endmodule

[rtl/ordered_dither_dot_plane_writer_unit.sv]
// Top level of the ordered dither dot plane writer.
// Depends on odw_pkg, odw_front, odw_queue and odw_back.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel takes one source pixel per request: four intensities, the row
//   number's low bits, a first-of-row mark and a repeat count (runs above
//   MAX_REPEAT are cut to MAX_REPEAT). m_* channel gives one request per
//   printer dot: position, clear flags for blue, green and red, last-of-run.
//   cfg_* writes one register per request (0 threshold, 1 colour mode,
//   2/3 dither matrix rows, 4 start position); always ready, write when idle.
// Timing:
//   A taken pixel passes the queue slot and the sequencer's pixel register,
//   then its first dot enters the output register. A pixel with repeat
//   count N gets a load step, then N dots, one dot per cycle while the output
//   register is free; a zero count only reloads a first-of-row start position.
//   The two-entry queue keeps the input accepting while the sequencer works.
// Reset (aresetn low, synchronous): registers, dot position and queue clear.
// Stall: with m_ready low the dot holds in the output register, the sequencer
//   waits, and s_ready drops once the queue is full.
//
module ordered_dither_dot_plane_writer_unit #(
    parameter int POSITION_BITS = odw_pkg::POSITION_BITS,
    parameter int QUEUE_DEPTH   = odw_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [odw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [odw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_first_of_row,
    input  logic [1:0]                      s_row_low,
    input  logic [7:0]                      s_white_level,
    input  logic [7:0]                      s_yellow_level,
    input  logic [7:0]                      s_magenta_level,
    input  logic [7:0]                      s_cyan_level,
    input  logic [odw_pkg::REPEAT_W-1:0]    s_repeat_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [POSITION_BITS-1:0]        m_dot_position,
    output logic                            m_clear_blue,
    output logic                            m_clear_green,
    output logic                            m_clear_red,
    output logic                            m_last_of_run
);

    logic                           push_valid;
    logic                           push_ready;
    odw_pkg::item_t                 push_item;
    logic                           pop_valid;
    logic                           pop_ready;
    odw_pkg::item_t                 pop_item;
    logic [odw_pkg::START_W-1:0]    start_position;

    // accept and classify
    odw_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_of_row  (s_first_of_row),
        .s_row_low       (s_row_low),
        .s_white_level   (s_white_level),
        .s_yellow_level  (s_yellow_level),
        .s_magenta_level (s_magenta_level),
        .s_cyan_level    (s_cyan_level),
        .s_repeat_count  (s_repeat_count),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item),
        .start_position  (start_position)
    );

    // decoupling queue
    odw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // dot sequencer and output register
    odw_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start_position (start_position),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dot_position (m_dot_position),
        .m_clear_blue   (m_clear_blue),
        .m_clear_green  (m_clear_green),
        .m_clear_red    (m_clear_red),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
